// ===== rtl/nrtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrtp_pkg
// Shared constants, types and lookup functions for the RMC time parser.
// ----------------------------------------------------------------------------
package nrtp_pkg;

  localparam int LINE_MAX_DEFAULT = 80;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;

  localparam int HDR_LEN    = 7;
  localparam int DIGITS     = 6;
  localparam int FIELD_TIME = 1;
  localparam int FIELD_STAT = 2;
  localparam int FIELD_DATE = 9;

  // Days from 1970-01-01 to 2000-01-01.
  localparam logic [15:0] DAYS_TO_2000 = 16'd10957;

  // Everything the parser hands on about one finished sentence.
  typedef struct packed {
    logic            tv;
    logic            fix;
    logic            derr;
    logic [5:0][3:0] td;
    logic [5:0][3:0] dd;
  } nrtp_line_t;

  // Characters of the "$GNRMC," sentence header.
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4e;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4d;
      3'd5:    c = 8'h43;
      3'd6:    c = 8'h2c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Days before the first of a month, for a zero-based month index.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Two decimal digits to a binary value.
  function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
    return 7'({3'b0, hi} * 7'd10 + {3'b0, lo});
  endfunction

endpackage

// ===== rtl/nmea_rmc_time_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_time_parser
// Frames NMEA text into lines and extracts UTC time, date and fix status
// from $GNRMC sentences, with seconds since 1970 for years 2000-2099.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while in_stall is low. A
// line ends at a line feed or at byte LINE_MAX-1, which belongs to the line.
// Each line that starts with "$GNRMC," produces one result transaction; other
// lines produce none. A result passes the sentence parser, then a stage that
// converts digits to day count and second of day, then the epoch multiply-add.
// Stall on the output backs up through these three registers to in_stall, so
// bytes keep flowing while a finished result waits to be taken, until the
// sentence parser register holds one that cannot move on. Empty time fields
// give time_valid 0 and all-zero values; bad or short digit fields, or a
// month or day out of range, set format_error and force epoch_seconds to zero.
module nmea_rmc_time_parser #(
  parameter int LINE_MAX = nrtp_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        time_valid,
  output logic        fix_valid,
  output logic [6:0]  hour,
  output logic [6:0]  minute,
  output logic [6:0]  second,
  output logic [6:0]  day,
  output logic [6:0]  month,
  output logic [6:0]  year,
  output logic [31:0] epoch_seconds,
  output logic        format_error
);
  import nrtp_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX);

  typedef struct packed {
    logic missing;
    logic short_fld;
  } close_t;

  // Parser state.
  logic [POS_W-1:0] line_position, line_position_next;
  logic             header_match, header_match_next;
  logic [3:0]       field_count, field_count_next;
  logic [2:0]       char_in_field, char_in_field_next;
  logic [5:0][3:0]  time_digits, time_digits_next;
  logic [5:0][3:0]  date_digits, date_digits_next;
  logic             time_missing, time_missing_next;
  logic             digit_error, digit_error_next;
  logic             fix_flag, fix_flag_next;
  logic             status_seen, status_seen_next;
  logic             status_a, status_a_next;

  logic       line_end;
  logic       emit;
  logic       in_take;
  nrtp_line_t line_info;

  // Pipeline registers.
  logic       s1_valid;
  nrtp_line_t s1;
  logic       s2_valid;
  logic       s2_tv, s2_fix, s2_err;
  logic [6:0] s2_hh, s2_mi, s2_ss, s2_dd, s2_mo, s2_yy;
  logic [15:0] s2_days;
  logic [18:0] s2_sod;

  logic out_load, s2_load, s1_move;

  function automatic close_t close_check(input logic [3:0] fc, input logic [2:0] cif);
    close_t r;
    r.missing   = (fc == 4'(FIELD_TIME)) && (cif == 3'd0);
    r.short_fld = ((fc == 4'(FIELD_TIME)) && (cif != 3'd0) && (cif < 3'(DIGITS))) ||
                  ((fc == 4'(FIELD_DATE)) && (cif < 3'(DIGITS)));
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // Handshake chain: each stage moves when the one after it has room.
  assign out_load = s2_valid && (!out_valid || !out_stall);
  assign s2_load  = s1_valid && (!s2_valid || out_load);
  assign s1_move  = s2_load;
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    close_t     c_comma;
    close_t     c_end;
    logic [3:0] nib;
    logic       bad;

    line_position_next = line_position;
    header_match_next  = header_match;
    field_count_next   = field_count;
    char_in_field_next = char_in_field;
    time_digits_next   = time_digits;
    date_digits_next   = date_digits;
    time_missing_next  = time_missing;
    digit_error_next   = digit_error;
    status_seen_next   = status_seen;
    status_a_next      = status_a;
    fix_flag_next      = fix_flag;

    c_comma = close_check(field_count, char_in_field);
    bad     = !is_digit(rx_byte);
    nib     = bad ? 4'd0 : rx_byte[3:0];

    line_end = (rx_byte == CHAR_LF) || (line_position >= POS_W'(LINE_MAX - 1));

    if (line_position < POS_W'(HDR_LEN)) begin
      if (rx_byte != hdr_char(line_position[2:0])) begin
        header_match_next = 1'b0;
      end
      if ((line_position == POS_W'(HDR_LEN - 1)) && header_match_next) begin
        field_count_next   = 4'(FIELD_TIME);
        char_in_field_next = 3'd0;
      end
    end else if (header_match) begin
      // The status letter is whatever byte opens field 2, even a delimiter.
      if ((field_count == 4'(FIELD_STAT)) && (char_in_field == 3'd0)) begin
        status_seen_next = 1'b1;
        status_a_next    = (rx_byte == CHAR_A);
      end
      if (rx_byte == CHAR_COMMA) begin
        if (c_comma.missing) begin
          time_missing_next = 1'b1;
        end
        if (c_comma.short_fld) begin
          digit_error_next = 1'b1;
        end
        if (field_count != 4'd15) begin
          field_count_next = field_count + 4'd1;
        end
        char_in_field_next = 3'd0;
      end else if (rx_byte != CHAR_LF) begin
        if (char_in_field < 3'(DIGITS)) begin
          if (field_count == 4'(FIELD_TIME)) begin
            time_digits_next[3'(DIGITS - 1) - char_in_field] = nib;
            if (bad) begin
              digit_error_next = 1'b1;
            end
          end else if (field_count == 4'(FIELD_DATE)) begin
            date_digits_next[3'(DIGITS - 1) - char_in_field] = nib;
            if (bad) begin
              digit_error_next = 1'b1;
            end
          end
        end
        if (char_in_field != 3'd7) begin
          char_in_field_next = char_in_field + 3'd1;
        end
      end
    end

    // Close the last field of the line.
    c_end = close_check(field_count_next, char_in_field_next);
    if (line_end) begin
      if (c_end.missing) begin
        time_missing_next = 1'b1;
      end
      if (c_end.short_fld || (field_count_next < 4'(FIELD_DATE))) begin
        digit_error_next = 1'b1;
      end
    end

    emit = line_end && header_match_next;

    line_info.tv   = !time_missing_next;
    line_info.derr = digit_error_next;
    line_info.td   = time_digits_next;
    line_info.dd   = date_digits_next;
    if (emit && !time_missing_next && status_seen_next) begin
      fix_flag_next = status_a_next;
    end
    line_info.fix  = fix_flag_next;

    if (!line_end) begin
      line_position_next = line_position + POS_W'(1);
    end
  end

  // Sentence parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      header_match  <= 1'b1;
      field_count   <= '0;
      char_in_field <= '0;
      time_digits   <= '0;
      date_digits   <= '0;
      time_missing  <= 1'b0;
      digit_error   <= 1'b0;
      status_seen   <= 1'b0;
      status_a      <= 1'b0;
      fix_flag      <= 1'b0;
    end else if (in_take) begin
      if (line_end) begin
        line_position <= '0;
        header_match  <= 1'b1;
        field_count   <= '0;
        char_in_field <= '0;
        time_digits   <= '0;
        date_digits   <= '0;
        time_missing  <= 1'b0;
        digit_error   <= 1'b0;
        status_seen   <= 1'b0;
        status_a      <= 1'b0;
        if (emit) begin
          fix_flag <= fix_flag_next;
        end
      end else begin
        line_position <= line_position_next;
        header_match  <= header_match_next;
        field_count   <= field_count_next;
        char_in_field <= char_in_field_next;
        time_digits   <= time_digits_next;
        date_digits   <= date_digits_next;
        time_missing  <= time_missing_next;
        digit_error   <= digit_error_next;
        status_seen   <= status_seen_next;
        status_a      <= status_a_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      s1 <= line_info;
    end
  end

  // Digit conversion, range check, day count and second of day.
  logic [6:0]  c_hh, c_mi, c_ss, c_dd, c_mo, c_yy;
  logic        c_err;
  logic [3:0]  c_midx;
  logic [15:0] c_days;
  logic [18:0] c_sod;
  logic [6:0]  c_yq;

  always_comb begin
    c_hh  = pair_val(s1.td[5], s1.td[4]);
    c_mi  = pair_val(s1.td[3], s1.td[2]);
    c_ss  = pair_val(s1.td[1], s1.td[0]);
    c_dd  = pair_val(s1.dd[5], s1.dd[4]);
    c_mo  = pair_val(s1.dd[3], s1.dd[2]);
    c_yy  = pair_val(s1.dd[1], s1.dd[0]);
    c_err = s1.derr || (c_mo < 7'd1) || (c_mo > 7'd12) || (c_dd < 7'd1) || (c_dd > 7'd31);
    c_midx = ((c_mo >= 7'd1) && (c_mo <= 7'd12)) ? 4'(c_mo - 7'd1) : 4'd0;
    c_yq  = (c_yy + 7'd3) >> 2;
    c_days = 16'(DAYS_TO_2000 + 16'({9'b0, c_yy} * 16'd365) + {9'b0, c_yq} +
                  {7'b0, month_start(c_midx)} +
                  {15'b0, (c_yy[1:0] == 2'b00) && (c_mo > 7'd2)} +
                  {9'b0, c_dd} - 16'd1);
    c_sod = 19'({12'b0, c_hh} * 19'd3600 + {12'b0, c_mi} * 19'd60 + {12'b0, c_ss});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (out_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_tv   <= s1.tv;
      s2_fix  <= s1.fix;
      s2_hh   <= s1.tv ? c_hh : 7'd0;
      s2_mi   <= s1.tv ? c_mi : 7'd0;
      s2_ss   <= s1.tv ? c_ss : 7'd0;
      s2_dd   <= s1.tv ? c_dd : 7'd0;
      s2_mo   <= s1.tv ? c_mo : 7'd0;
      s2_yy   <= s1.tv ? c_yy : 7'd0;
      s2_err  <= s1.tv && c_err;
      s2_days <= c_days;
      s2_sod  <= c_sod;
    end
  end

  // Output register with the epoch multiply-add.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      time_valid    <= s2_tv;
      fix_valid     <= s2_fix;
      hour          <= s2_hh;
      minute        <= s2_mi;
      second        <= s2_ss;
      day           <= s2_dd;
      month         <= s2_mo;
      year          <= s2_yy;
      format_error  <= s2_err;
      epoch_seconds <= (s2_tv && !s2_err) ?
                       32'({16'b0, s2_days} * 32'd86400 + {13'b0, s2_sod}) : 32'd0;
    end
  end

endmodule
